FILE: design/assert_macros.svh
// Assertion macros used by rlsd_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define RLSD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also runs during reset.
`define RLSD_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/rlsd_pkg.sv
// Shared types, codes and microcode table of the LED matrix scan driver.
// No dependencies.
package rlsd_pkg;

  localparam int PANEL_WIDTH_DEF  = 32;
  localparam int PANEL_HEIGHT_DEF = 32;
  localparam int SCAN_ROWS_DEF    = 16;
  localparam int PIXEL_W          = 3;
  localparam logic [15:0] ON_TIME_RST = 16'd100;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] x_pos;
    logic [4:0] y_pos;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
  } in_t;

  typedef struct packed {
    logic [3:0] row_select;
    logic [2:0] first_half_rgb;
    logic [2:0] second_half_rgb;
    logic       shift_clock;
    logic       latch_pulse;
    logic       output_enable;
    logic       frame_done;
    logic       scan_busy;
  } out_t;

  // Microprogram step addresses
  localparam logic [1:0] UPC_DISPATCH = 2'd0;
  localparam logic [1:0] UPC_EMIT     = 2'd1;
  localparam logic [1:0] UPC_CLEAR    = 2'd2;

  typedef enum logic [1:0] {
    SEQ_DISPATCH = 2'd0,
    SEQ_WAIT_OUT = 2'd1,
    SEQ_LOOP_CLR = 2'd2,
    SEQ_GOTO     = 2'd3
  } seq_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic       clr_wr;
    seq_t       seq;
    logic [1:0] target;
  } uc_word_t;

  typedef struct packed {
    logic take_en;
    logic emit;
    logic clr_wr;
  } ctl_t;

  function automatic uc_word_t uc_rom(input logic [1:0] upc);
    uc_word_t w;
    w = '{take: 1'b0, emit: 1'b0, clr_wr: 1'b0, seq: SEQ_GOTO, target: UPC_DISPATCH};
    case (upc)
      UPC_DISPATCH: begin
        w.take = 1'b1;
        w.seq  = SEQ_DISPATCH;
      end
      UPC_EMIT: begin
        w.emit = 1'b1;
        w.seq  = SEQ_WAIT_OUT;
      end
      UPC_CLEAR: begin
        w.clr_wr = 1'b1;
        w.seq    = SEQ_LOOP_CLR;
      end
      default: begin
        w.seq = SEQ_GOTO;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/rlsd_ram.sv
// Generic RAM: one write port, two read ports, registered read.
// No dependencies.
module rlsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/rlsd_useq.sv
// Microcode sequencer: step counter, control ROM, dispatch and clear loop counter.
// Depends on rlsd_pkg.
module rlsd_useq #(
  parameter int DEPTH = rlsd_pkg::PANEL_WIDTH_DEF * rlsd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [1:0]               mode,
  input  logic                     out_free,
  output rlsd_pkg::ctl_t           ctl,
  output logic [$clog2(DEPTH)-1:0] clr_addr
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  logic [1:0]         upc_r, upc_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  rlsd_pkg::uc_word_t word;
  logic               clr_last;

  assign word     = rlsd_pkg::uc_rom(upc_r);
  assign clr_last = (clr_r == CLR_LAST);
  assign clr_addr = clr_r;

  always_comb begin
    ctl.take_en = word.take;
    ctl.emit    = word.emit && out_free;
    ctl.clr_wr  = word.clr_wr;
  end

  always_comb begin
    upc_nxt = upc_r;
    case (word.seq)
      rlsd_pkg::SEQ_DISPATCH: begin
        if (in_valid) begin
          case (mode)
            rlsd_pkg::MODE_TICK:  upc_nxt = rlsd_pkg::UPC_EMIT;
            rlsd_pkg::MODE_CLEAR: upc_nxt = rlsd_pkg::UPC_CLEAR;
            default:              upc_nxt = word.target;
          endcase
        end
      end
      rlsd_pkg::SEQ_WAIT_OUT: begin
        if (out_free) upc_nxt = word.target;
      end
      rlsd_pkg::SEQ_LOOP_CLR: begin
        if (clr_last) upc_nxt = word.target;
      end
      default: begin
        upc_nxt = word.target;
      end
    endcase
  end

  always_comb begin
    clr_nxt = clr_r;
    if (word.clr_wr) clr_nxt = clr_last ? '0 : clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rlsd_pkg::UPC_CLEAR;
      clr_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      clr_r <= clr_nxt;
    end
  end

endmodule

FILE: design/rlsd_scan.sv
// Scan datapath: row, phase and hold counters, store read addresses, pin word.
// Depends on rlsd_pkg.
module rlsd_scan #(
  parameter int PANEL_WIDTH  = rlsd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rlsd_pkg::PANEL_HEIGHT_DEF,
  parameter int SCAN_ROWS    = rlsd_pkg::SCAN_ROWS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic                                      rd_issue,
  input  logic                                      emit,
  input  logic [15:0]                               on_time,
  input  logic [rlsd_pkg::PIXEL_W-1:0]              rd_top,
  input  logic [rlsd_pkg::PIXEL_W-1:0]              rd_bot,
  output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT)-1:0] rd_addr_top,
  output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT)-1:0] rd_addr_bot,
  output rlsd_pkg::out_t                            res
);

  localparam int AW = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
  localparam int RW = $clog2(SCAN_ROWS);
  localparam int PW = $clog2(PANEL_WIDTH + 4);
  localparam logic [PW-1:0] PH_LATCH = PW'(PANEL_WIDTH);
  localparam logic [PW-1:0] PH_HOLD  = PW'(PANEL_WIDTH + 1);
  localparam logic [PW-1:0] PH_OPEN  = PW'(PANEL_WIDTH + 2);
  localparam logic [PW-1:0] PH_FINAL = PW'(PANEL_WIDTH + 3);

  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [15:0]   hold_r, hold_nxt;
  logic          active_r, active_nxt;
  logic          lit_r, lit_nxt;
  logic          top_ok_r, bot_ok_r;
  logic [15:0]   limit;
  logic [16:0]   hold_inc;
  logic          last_row;

  assign rd_addr_top = AW'(32'(row_r) * 32'(PANEL_WIDTH) + 32'(phase_r));
  assign rd_addr_bot = AW'((32'(row_r) + 32'(SCAN_ROWS)) * 32'(PANEL_WIDTH) + 32'(phase_r));

  assign limit    = (on_time == 16'd0) ? 16'd1 : on_time;
  assign hold_inc = {1'b0, hold_r} + 17'd1;
  assign last_row = (32'(row_r) + 32'd1) >= 32'(SCAN_ROWS);

  always_comb begin
    row_nxt    = row_r;
    phase_nxt  = phase_r;
    hold_nxt   = hold_r;
    active_nxt = active_r;
    lit_nxt    = lit_r;
    res        = '0;
    if (start && !active_r) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
      phase_nxt  = PH_OPEN;
      hold_nxt   = '0;
    end
    if (emit) begin
      if (active_r) begin
        res.scan_busy = 1'b1;
        if (phase_r == PH_OPEN) begin
          row_nxt         = '0;
          res.latch_pulse = 1'b1;
          phase_nxt       = '0;
        end else if (phase_r < PH_LATCH) begin
          lit_nxt             = 1'b0;
          res.first_half_rgb  = top_ok_r ? rd_top : '0;
          res.second_half_rgb = bot_ok_r ? rd_bot : '0;
          res.shift_clock     = 1'b1;
          phase_nxt           = phase_r + 1'b1;
        end else if (phase_r == PH_LATCH) begin
          lit_nxt         = 1'b1;
          res.latch_pulse = 1'b1;
          hold_nxt        = '0;
          phase_nxt       = PH_HOLD;
        end else if (phase_r == PH_HOLD) begin
          hold_nxt = hold_inc[15:0];
          if (hold_inc >= {1'b0, limit}) begin
            hold_nxt = '0;
            if (last_row) begin
              phase_nxt = PH_FINAL;
            end else begin
              row_nxt   = row_r + 1'b1;
              phase_nxt = '0;
            end
          end
        end else begin
          lit_nxt        = 1'b0;
          res.frame_done = 1'b1;
          active_nxt     = 1'b0;
          phase_nxt      = '0;
        end
      end else begin
        lit_nxt = 1'b0;
      end
      res.row_select    = 4'(row_nxt);
      res.output_enable = lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      phase_r  <= '0;
      hold_r   <= '0;
      active_r <= 1'b0;
      lit_r    <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      active_r <= active_nxt;
      lit_r    <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      top_ok_r <= 32'(row_r) < 32'(PANEL_HEIGHT);
      bot_ok_r <= (32'(row_r) + 32'(SCAN_ROWS)) < 32'(PANEL_HEIGHT);
    end
  end

endmodule

FILE: design/rgb_led_matrix_scan_driver_core.sv
// Top level of the RGB LED matrix scan driver: pixel store, sequencer, scan datapath.
// Depends on rlsd_pkg, rlsd_ram, rlsd_useq and rlsd_scan.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   rlsd_pkg::in_t
//   out_     output     out_valid/out_stall rlsd_pkg::out_t
//   cfg_     input      cfg_valid/cfg_ready on_time_ticks, 16 bits
//
// Write and start are done at dispatch; a tick does a store read, then a pin word.
// Clear sweeps the store, one entry a cycle, writing zero to each.
// After reset the same sweep runs with in_stall high.
// A stalled pin word sits in the output register; the next tick waits for it.
module rgb_led_matrix_scan_driver_core #(
  parameter int PANEL_WIDTH  = rlsd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rlsd_pkg::PANEL_HEIGHT_DEF,
  parameter int SCAN_ROWS    = rlsd_pkg::SCAN_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlsd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PXW   = rlsd_pkg::PIXEL_W;

  rlsd_pkg::ctl_t ctl;
  rlsd_pkg::out_t res;
  rlsd_pkg::out_t out_data_r;
  logic           out_valid_r;
  logic [15:0]    on_time_r;
  logic           accept, out_free, pix_ok, wr_en;
  logic [AW-1:0]  clr_addr, pix_addr, wr_addr, rd_addr_top, rd_addr_bot;
  logic [PXW-1:0] wr_data, rd_top, rd_bot, color;

  assign in_stall  = !ctl.take_en;
  assign accept    = in_valid && ctl.take_en;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign pix_ok   = (32'(in_data.x_pos) < 32'(PANEL_WIDTH)) &&
                    (32'(in_data.y_pos) < 32'(PANEL_HEIGHT));
  assign pix_addr = AW'(32'(in_data.y_pos) * 32'(PANEL_WIDTH) +
                        (32'(PANEL_WIDTH - 1) - 32'(in_data.x_pos)));
  assign color    = {in_data.blue_on, in_data.green_on, in_data.red_on};

  assign wr_en   = ctl.clr_wr ||
                   (accept && in_data.mode == rlsd_pkg::MODE_WRITE && pix_ok);
  assign wr_addr = ctl.clr_wr ? clr_addr : pix_addr;
  assign wr_data = ctl.clr_wr ? '0 : color;

  rlsd_useq #(
    .DEPTH (DEPTH)
  ) u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .mode     (in_data.mode),
    .out_free (out_free),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  rlsd_ram #(
    .WIDTH (PXW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (accept && in_data.mode == rlsd_pkg::MODE_TICK),
    .raddr_a (rd_addr_top),
    .raddr_b (rd_addr_bot),
    .rdata_a (rd_top),
    .rdata_b (rd_bot)
  );

  rlsd_scan #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .SCAN_ROWS    (SCAN_ROWS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && in_data.mode == rlsd_pkg::MODE_START),
    .rd_issue    (accept && in_data.mode == rlsd_pkg::MODE_TICK),
    .emit        (ctl.emit),
    .on_time     (on_time_r),
    .rd_top      (rd_top),
    .rd_bot      (rd_bot),
    .rd_addr_top (rd_addr_top),
    .rd_addr_bot (rd_addr_bot),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      on_time_r   <= rlsd_pkg::ON_TIME_RST;
    end else begin
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) on_time_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) out_data_r <= res;
  end

endmodule

FILE: design/rlsd_checker.sv
// Port-level checks of the LED matrix scan driver, bound to its top level.
// Depends on rlsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rlsd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rlsd_pkg::out_t out_data
);

  logic out_held;
  logic done_word;
  logic shift_word;
  logic quiet;

  assign out_held   = out_valid && out_stall;
  assign done_word  = out_valid && out_data.frame_done;
  assign shift_word = out_valid && out_data.shift_clock;
  assign quiet      = out_data.scan_busy && !out_data.output_enable && !out_data.latch_pulse;

  `RLSD_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_data), "stall not held")
  `RLSD_ASSERT(a_done_blank, clk, rst_n, done_word |-> quiet, "frame end not blanked")
  `RLSD_ASSERT(a_shift_dark, clk, rst_n, shift_word |-> quiet, "shift while lit or latching")
  `RLSD_ASSERT_RST(a_rst_sweep, clk, !rst_n |=> in_stall, "input taken during store sweep")

endmodule

bind rgb_led_matrix_scan_driver_core rlsd_checker u_rlsd_checker (.*);
